[hw/rtl/bor_pkg.sv]
// Shared constants, mode codes and helpers for the box overlap ratio pipeline.
// No dependencies; imported by box_overlap_ratio.
`timescale 1ns / 1ps
`default_nettype none

package bor_pkg;

    // Coordinates are read from their low COORD_BITS bits as two's complement.
    localparam int COORD_BITS = 16;
    // Fraction bits of the ratio; 1 << FRAC_BITS means 1.0.
    localparam int FRAC_BITS  = 16;

    localparam int MODE_W  = 2;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int RATIO_W = 17;

    // Edge arithmetic: coordinate plus size, with a spare bit for differences.
    localparam int EDGE_W  = ((COORD_BITS > COORD_W) ? COORD_BITS : COORD_W) + 2;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int DEN_W   = AREA_W + 1;
    // Overlap never exceeds the denominator, so the quotient is at most 1.0.
    localparam int QUO_BITS = FRAC_BITS + 1;
    localparam int SAT_W    = (QUO_BITS > RATIO_W) ? QUO_BITS : RATIO_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_UNION  = 2'd0,
        MODE_AREA_A = 2'd1,
        MODE_AREA_B = 2'd2
    } mode_t;

    // Sign-extend a coordinate from bit COORD_BITS-1 to the edge width.
    function automatic logic signed [EDGE_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
        logic [EDGE_W-1:0] r;
        logic              sgn;
        sgn = (COORD_BITS <= COORD_W) ? v[COORD_BITS-1] : 1'b0;
        for (int i = 0; i < EDGE_W; i++) begin
            if (i < COORD_BITS)
                r[i] = (i < COORD_W) ? v[i] : 1'b0;
            else
                r[i] = sgn;
        end
        return signed'(r);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/box_overlap_ratio.sv]
// Box overlap ratio: overlap area of two axis-aligned boxes over a chosen area.
// Pipeline: 4 geometry stages, 17 restoring-division stages and 1 output register
// between an accepted start and done; one transaction per cycle.
// The division stages set the depth: one quotient bit per stage.
// busy stays low: the pipeline never stalls since the receiver cannot hold results.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module box_overlap_ratio (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bor_pkg::MODE_W-1:0]    mode,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_a_x,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_a_y,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_a_w,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_a_h,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_b_x,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_b_y,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_b_w,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_b_h,
    output logic                               done,
    output logic [bor_pkg::RATIO_W-1:0]        ratio,
    output logic                               zero_denominator
);

    import bor_pkg::*;

    // ------------------------------------------------------------------
    // Stage 1: sign-extend corners, form far edges, larger near edges,
    // and both box areas.
    // ------------------------------------------------------------------
    logic                     accept;
    logic signed [EDGE_W-1:0] ax_s, ay_s, bx_s, by_s;
    logic signed [EDGE_W-1:0] aw_s, ah_s, bw_s, bh_s;

    logic                     s1_vld_reg;
    logic [MODE_W-1:0]        s1_mode_reg;
    logic signed [EDGE_W-1:0] s1_lo_x_reg, s1_ea_x_reg, s1_eb_x_reg;
    logic signed [EDGE_W-1:0] s1_lo_y_reg, s1_ea_y_reg, s1_eb_y_reg;
    logic [AREA_W-1:0]        s1_area_a_reg, s1_area_b_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_comb
    begin
        ax_s = sext_coord(box_a_x);
        ay_s = sext_coord(box_a_y);
        bx_s = sext_coord(box_b_x);
        by_s = sext_coord(box_b_y);
        aw_s = signed'(EDGE_W'(box_a_w));
        ah_s = signed'(EDGE_W'(box_a_h));
        bw_s = signed'(EDGE_W'(box_b_w));
        bh_s = signed'(EDGE_W'(box_b_h));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg   <= mode;
        s1_lo_x_reg   <= (ax_s > bx_s) ? ax_s : bx_s;
        s1_lo_y_reg   <= (ay_s > by_s) ? ay_s : by_s;
        s1_ea_x_reg   <= ax_s + aw_s;
        s1_eb_x_reg   <= bx_s + bw_s;
        s1_ea_y_reg   <= ay_s + ah_s;
        s1_eb_y_reg   <= by_s + bh_s;
        s1_area_a_reg <= AREA_W'(box_a_w) * AREA_W'(box_a_h);
        s1_area_b_reg <= AREA_W'(box_b_w) * AREA_W'(box_b_h);
    end

    // ------------------------------------------------------------------
    // Stage 2: overlap width and height, clamped to zero when empty.
    // The overlap never exceeds the smaller size, so it fits a size field.
    // ------------------------------------------------------------------
    logic signed [EDGE_W-1:0] hi_x, hi_y, dx, dy;

    logic                     s2_vld_reg;
    logic [MODE_W-1:0]        s2_mode_reg;
    logic [SIZE_W-1:0]        s2_iw_reg, s2_ih_reg;
    logic [AREA_W-1:0]        s2_area_a_reg, s2_area_b_reg;

    always_comb
    begin
        hi_x = (s1_ea_x_reg < s1_eb_x_reg) ? s1_ea_x_reg : s1_eb_x_reg;
        hi_y = (s1_ea_y_reg < s1_eb_y_reg) ? s1_ea_y_reg : s1_eb_y_reg;
        dx   = hi_x - s1_lo_x_reg;
        dy   = hi_y - s1_lo_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg   <= s1_mode_reg;
        s2_iw_reg     <= (dx > 0) ? SIZE_W'(dx) : '0;
        s2_ih_reg     <= (dy > 0) ? SIZE_W'(dy) : '0;
        s2_area_a_reg <= s1_area_a_reg;
        s2_area_b_reg <= s1_area_b_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: overlap area (zero whenever either span is zero).
    // ------------------------------------------------------------------
    logic              s3_vld_reg;
    logic [MODE_W-1:0] s3_mode_reg;
    logic [AREA_W-1:0] s3_inter_reg, s3_area_a_reg, s3_area_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_mode_reg   <= s2_mode_reg;
        s3_inter_reg  <= AREA_W'(s2_iw_reg) * AREA_W'(s2_ih_reg);
        s3_area_a_reg <= s2_area_a_reg;
        s3_area_b_reg <= s2_area_b_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the denominator. Unused mode code falls back to union.
    // The overlap is within each area, so the union never goes negative.
    // ------------------------------------------------------------------
    logic [DEN_W-1:0] den_next;

    always_comb
    begin
        case (mode_t'(s3_mode_reg))
            MODE_AREA_A: den_next = DEN_W'(s3_area_a_reg);
            MODE_AREA_B: den_next = DEN_W'(s3_area_b_reg);
            default:     den_next = DEN_W'(s3_area_a_reg) + DEN_W'(s3_area_b_reg)
                                    - DEN_W'(s3_inter_reg);
        endcase
    end

    // Division pipeline registers: index 0 is loaded by stage 4, index k+1
    // holds the partial result after quotient stage k.
    logic                div_vld_reg  [QUO_BITS+1];
    logic                div_zero_reg [QUO_BITS+1];
    logic [DEN_W-1:0]    div_den_reg  [QUO_BITS+1];
    logic [DEN_W-1:0]    div_rem_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] div_quo_reg  [QUO_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_vld_reg[0] <= 1'b0;
        else
            div_vld_reg[0] <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        div_den_reg[0]  <= den_next;
        div_zero_reg[0] <= (den_next == '0);
        div_rem_reg[0]  <= DEN_W'(s3_inter_reg);
        div_quo_reg[0]  <= '0;
    end

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage, MSB first. The first
    // stage tests the overlap itself (the integer bit, set only at 1.0);
    // each later stage doubles the remainder before the trial subtract.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_div
        logic [DEN_W:0] trial;
        logic           ge;

        always_comb
        begin
            if (k == 0)
                trial = {1'b0, div_rem_reg[k]};
            else
                trial = {div_rem_reg[k], 1'b0};
            ge = (trial >= {1'b0, div_den_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_vld_reg[k+1] <= 1'b0;
            else
                div_vld_reg[k+1] <= div_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            div_den_reg[k+1]  <= div_den_reg[k];
            div_zero_reg[k+1] <= div_zero_reg[k];
            div_rem_reg[k+1]  <= ge ? DEN_W'(trial - {1'b0, div_den_reg[k]})
                                    : DEN_W'(trial);
            div_quo_reg[k+1]  <= {div_quo_reg[k][QUO_BITS-2:0], ge};
        end
    end

    // ------------------------------------------------------------------
    // Output register: force zero on an empty denominator, saturate when
    // the quotient would not fit the ratio field.
    // ------------------------------------------------------------------
    logic [SAT_W-1:0]   quo_wide;
    logic [RATIO_W-1:0] ratio_next;

    logic               done_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               zero_reg;

    always_comb
    begin
        quo_wide = SAT_W'(div_quo_reg[QUO_BITS]);
        if (div_zero_reg[QUO_BITS])
            ratio_next = '0;
        else if (quo_wide > SAT_W'({RATIO_W{1'b1}}))
            ratio_next = '1;
        else
            ratio_next = RATIO_W'(quo_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_vld_reg[QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        ratio_reg <= ratio_next;
        zero_reg  <= div_zero_reg[QUO_BITS];
    end

    assign done             = done_reg;
    assign ratio            = ratio_reg;
    assign zero_denominator = zero_reg;

endmodule

`default_nettype wire

[verif/bor_ratio_check.sv]
// Predicts and checks box overlap ratio results from the command and result ports.
// Depends on bor_pkg (widths, FRAC_BITS, mode codes); instantiated by tb_box_overlap_ratio.
`timescale 1ns / 1ps

module bor_ratio_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [bor_pkg::MODE_W-1:0]    mode,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_a_x,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_a_y,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_a_w,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_a_h,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_b_x,
    input  wire logic [bor_pkg::COORD_W-1:0]   box_b_y,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_b_w,
    input  wire logic [bor_pkg::SIZE_W-1:0]    box_b_h,
    input  wire logic                          done,
    input  wire logic [bor_pkg::RATIO_W-1:0]   ratio,
    input  wire logic                          zero_denominator,
    output int                                 ratio_errors,
    output int                                 results_pending
);

    localparam longint unsigned RATIO_CEIL = (64'd1 << bor_pkg::RATIO_W) - 1;

    typedef struct {
        logic [bor_pkg::RATIO_W-1:0] ratio;
        logic                        zero_den;
    } overlap_ratio_t;

    overlap_ratio_t predicted_ratios[$];

    // Length of the common part of two spans; zero when they do not overlap.
    function automatic longint span_common(input longint a0, input longint alen,
                                           input longint b0, input longint blen);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic overlap_ratio_t predict_overlap(
        input logic [bor_pkg::MODE_W-1:0]         sel,
        input logic signed [bor_pkg::COORD_W-1:0] ax,
        input logic signed [bor_pkg::COORD_W-1:0] ay,
        input logic [bor_pkg::SIZE_W-1:0]         aw,
        input logic [bor_pkg::SIZE_W-1:0]         ah,
        input logic signed [bor_pkg::COORD_W-1:0] bx,
        input logic signed [bor_pkg::COORD_W-1:0] by,
        input logic [bor_pkg::SIZE_W-1:0]         bw,
        input logic [bor_pkg::SIZE_W-1:0]         bh);
        longint          iw;
        longint          ih;
        longint unsigned inter;
        longint unsigned area_a;
        longint unsigned area_b;
        longint unsigned den;
        longint unsigned quo;
        overlap_ratio_t  res;
        iw     = span_common(longint'(ax), longint'(aw), longint'(bx), longint'(bw));
        ih     = span_common(longint'(ay), longint'(ah), longint'(by), longint'(bh));
        inter  = longint'(iw * ih);
        area_a = longint'(aw) * longint'(ah);
        area_b = longint'(bw) * longint'(bh);
        // The unused mode code falls back to the union area.
        case (bor_pkg::mode_t'(sel))
            bor_pkg::MODE_AREA_A: den = area_a;
            bor_pkg::MODE_AREA_B: den = area_b;
            default:              den = area_a + area_b - inter;
        endcase
        if (den == 0)
        begin
            res.ratio    = '0;
            res.zero_den = 1'b1;
        end
        else
        begin
            quo = (inter << bor_pkg::FRAC_BITS) / den;
            if (quo > RATIO_CEIL)
                quo = RATIO_CEIL;
            res.ratio    = quo[bor_pkg::RATIO_W-1:0];
            res.zero_den = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        overlap_ratio_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (predicted_ratios.size() == 0)
                begin
                    $error("result with no transaction pending: ratio %0d", ratio);
                    ratio_errors++;
                end
                else
                begin
                    want = predicted_ratios.pop_front();
                    if (ratio !== want.ratio)
                    begin
                        $error("ratio: expected %0d, actual %0d", want.ratio, ratio);
                        ratio_errors++;
                    end
                    if (zero_denominator !== want.zero_den)
                    begin
                        $error("zero_denominator: expected %0b, actual %0b",
                               want.zero_den, zero_denominator);
                        ratio_errors++;
                    end
                end
            end
            if (start && !busy)
                predicted_ratios = {predicted_ratios, predict_overlap(mode, box_a_x,
                    box_a_y, box_a_w, box_a_h, box_b_x, box_b_y, box_b_w, box_b_h)};
            results_pending = predicted_ratios.size();
        end
    end

endmodule

[verif/tb_box_overlap_ratio.sv]
// Stimulus and verdict for the box overlap ratio block: directed box pairs, then random ones.
// Depends on bor_pkg, box_overlap_ratio and bor_ratio_check.
`timescale 1ns / 1ps

module tb_box_overlap_ratio;

    // Cycles without any accepted transaction or result before the run is declared hung.
    // The pipeline is 22 deep, so anything near this limit means the block has stalled.
    localparam int STALL_LIMIT = 2000;
    // Cycles to linger after the last result so a stray extra strobe still gets caught.
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 600;

    // Mode code with no enum member; the block treats it as a union-area request.
    localparam logic [bor_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [bor_pkg::MODE_W-1:0]  mode;
        logic [bor_pkg::COORD_W-1:0] ax;
        logic [bor_pkg::COORD_W-1:0] ay;
        logic [bor_pkg::SIZE_W-1:0]  aw;
        logic [bor_pkg::SIZE_W-1:0]  ah;
        logic [bor_pkg::COORD_W-1:0] bx;
        logic [bor_pkg::COORD_W-1:0] by;
        logic [bor_pkg::SIZE_W-1:0]  bw;
        logic [bor_pkg::SIZE_W-1:0]  bh;
    } box_pair_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [bor_pkg::MODE_W-1:0]    mode;
    logic [bor_pkg::COORD_W-1:0]   box_a_x;
    logic [bor_pkg::COORD_W-1:0]   box_a_y;
    logic [bor_pkg::SIZE_W-1:0]    box_a_w;
    logic [bor_pkg::SIZE_W-1:0]    box_a_h;
    logic [bor_pkg::COORD_W-1:0]   box_b_x;
    logic [bor_pkg::COORD_W-1:0]   box_b_y;
    logic [bor_pkg::SIZE_W-1:0]    box_b_w;
    logic [bor_pkg::SIZE_W-1:0]    box_b_h;
    logic                          done;
    logic [bor_pkg::RATIO_W-1:0]   ratio;
    logic                          zero_denominator;

    int   ratio_errors;
    int   results_pending;
    logic taken = 1'b0;
    int   quiet_cycles = 0;

    always #10 clk = ~clk;

    box_overlap_ratio DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .box_a_x          (box_a_x),
        .box_a_y          (box_a_y),
        .box_a_w          (box_a_w),
        .box_a_h          (box_a_h),
        .box_b_x          (box_b_x),
        .box_b_y          (box_b_y),
        .box_b_w          (box_b_w),
        .box_b_h          (box_b_h),
        .done             (done),
        .ratio            (ratio),
        .zero_denominator (zero_denominator)
    );

    bor_ratio_check ratio_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .box_a_x          (box_a_x),
        .box_a_y          (box_a_y),
        .box_a_w          (box_a_w),
        .box_a_h          (box_a_h),
        .box_b_x          (box_b_x),
        .box_b_y          (box_b_y),
        .box_b_w          (box_b_w),
        .box_b_h          (box_b_h),
        .done             (done),
        .ratio            (ratio),
        .zero_denominator (zero_denominator),
        .ratio_errors     (ratio_errors),
        .results_pending  (results_pending)
    );

    // Latch at each rising edge whether a transaction went in, so the driver can
    // look at it on the following falling edge without racing the edge itself.
    always @(posedge clk)
        taken <= rst_n && start && !busy;

    // Watchdog: restart the count on every accepted transaction or result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic box_pair_t make_pair(input logic [bor_pkg::MODE_W-1:0] m,
                                            input int ax, input int ay,
                                            input int aw, input int ah,
                                            input int bx, input int by,
                                            input int bw, input int bh);
        box_pair_t p;
        p.mode = m;
        p.ax   = ax[bor_pkg::COORD_W-1:0];
        p.ay   = ay[bor_pkg::COORD_W-1:0];
        p.aw   = aw[bor_pkg::SIZE_W-1:0];
        p.ah   = ah[bor_pkg::SIZE_W-1:0];
        p.bx   = bx[bor_pkg::COORD_W-1:0];
        p.by   = by[bor_pkg::COORD_W-1:0];
        p.bw   = bw[bor_pkg::SIZE_W-1:0];
        p.bh   = bh[bor_pkg::SIZE_W-1:0];
        return p;
    endfunction

    // Mostly small boxes so overlaps are common; now and then a full-range or empty one.
    function automatic int rand_size();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return 0;
        else if (pick < 12)
            return $urandom_range(64, 1);
        else
            return $urandom_range(32767);
    endfunction

    function automatic box_pair_t rand_pair();
        box_pair_t p;
        int        pick;
        int        span;
        int        off;
        pick = $urandom_range(99);
        p.mode = ($urandom_range(9) == 0) ? MODE_UNUSED
                                          : bor_pkg::MODE_W'($urandom_range(2));
        // Fully random fields: every bit of every field toggles, overlaps are rare.
        p.ax = bor_pkg::COORD_W'($urandom);
        p.ay = bor_pkg::COORD_W'($urandom);
        p.aw = bor_pkg::SIZE_W'($urandom);
        p.ah = bor_pkg::SIZE_W'($urandom);
        p.bx = bor_pkg::COORD_W'($urandom);
        p.by = bor_pkg::COORD_W'($urandom);
        p.bw = bor_pkg::SIZE_W'($urandom);
        p.bh = bor_pkg::SIZE_W'($urandom);
        if (pick >= 15)
        begin
            p.aw = bor_pkg::SIZE_W'(rand_size());
            p.ah = bor_pkg::SIZE_W'(rand_size());
            p.bw = bor_pkg::SIZE_W'(rand_size());
            p.bh = bor_pkg::SIZE_W'(rand_size());
            if (pick < 25)
            begin
                // Identical boxes: ratio of exactly 1.0 unless the area is zero.
                p.bx = p.ax;
                p.by = p.ay;
                p.bw = p.aw;
                p.bh = p.ah;
            end
            else
            begin
                // Place B near A so the spans overlap, touch or just miss.
                span = int'(p.aw) + int'(p.bw) + 2;
                off  = int'($urandom_range(2 * span)) - span;
                p.bx = p.ax + off[bor_pkg::COORD_W-1:0];
                span = int'(p.ah) + int'(p.bh) + 2;
                off  = int'($urandom_range(2 * span)) - span;
                p.by = p.ay + off[bor_pkg::COORD_W-1:0];
            end
        end
        return p;
    endfunction

    // Present one box pair from a falling edge and hold it until the block takes it.
    task automatic issue(input box_pair_t p);
        mode    <= p.mode;
        box_a_x <= p.ax;
        box_a_y <= p.ay;
        box_a_w <= p.aw;
        box_a_h <= p.ah;
        box_b_x <= p.bx;
        box_b_y <= p.by;
        box_b_w <= p.bw;
        box_b_h <= p.bh;
        start   <= 1'b1;
        do
            @(negedge clk);
        while (!taken);
    endtask

    // Drop start and hold off until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // Random transactions; the sender idles in idle_pct cycles of a hundred.
    task automatic run_random(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
        begin
            issue(rand_pair());
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        mode    = bor_pkg::MODE_UNION;
        box_a_x = '0;
        box_a_y = '0;
        box_a_w = '0;
        box_a_h = '0;
        box_b_x = '0;
        box_b_y = '0;
        box_b_w = '0;
        box_b_h = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identical boxes under every mode code, including the unused one.
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 10, 10, 0, 0, 10, 10));
        issue(make_pair(bor_pkg::MODE_AREA_A, 0, 0, 10, 10, 0, 0, 10, 10));
        issue(make_pair(bor_pkg::MODE_AREA_B, 0, 0, 10, 10, 0, 0, 10, 10));
        issue(make_pair(MODE_UNUSED,          0, 0, 10, 10, 0, 0, 10, 10));
        // Partial overlaps, some with unequal box areas.
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 10, 10, 5, 5, 10, 10));
        issue(make_pair(bor_pkg::MODE_AREA_A, 0, 0, 20, 10, 5, 5, 10, 10));
        issue(make_pair(bor_pkg::MODE_AREA_B, 0, 0, 20, 10, 5, 5, 10, 10));
        issue(make_pair(bor_pkg::MODE_UNION,  -1, -1, 2, 2, 0, 0, 2, 2));
        // Disjoint boxes, and boxes that only share an edge.
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 10, 10, 100, 100, 5, 5));
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 10, 10, 10, 0, 10, 10));
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 10, 10, 0, 10, 10, 10));
        // Zero denominators: empty A, empty B, both empty, and the unused mode.
        issue(make_pair(bor_pkg::MODE_AREA_A, 0, 0, 0, 10, 0, 0, 10, 10));
        issue(make_pair(bor_pkg::MODE_AREA_B, 0, 0, 10, 10, 0, 0, 10, 0));
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 0, 0, 5, 5, 0, 7));
        issue(make_pair(MODE_UNUSED,          0, 0, 0, 0, 0, 0, 0, 0));
        // Empty A against a real B: union is just B, overlap is zero.
        issue(make_pair(bor_pkg::MODE_UNION,  0, 0, 0, 10, 0, 0, 10, 10));
        // Coordinate and size extremes.
        issue(make_pair(bor_pkg::MODE_UNION,  -32768, -32768, 32767, 32767,
                        -32768, -32768, 32767, 32767));
        issue(make_pair(bor_pkg::MODE_AREA_A, -32768, -32768, 32767, 32767,
                        32767, 32767, 32767, 32767));
        issue(make_pair(bor_pkg::MODE_UNION,  -32768, 32767, 32767, 32767,
                        -1, 32767, 32767, 32767));
        issue(make_pair(bor_pkg::MODE_UNION,  32767, 32767, 1, 1, 32767, 32767, 1, 1));
        // One box inside the other, seen from each side.
        issue(make_pair(bor_pkg::MODE_AREA_B, -100, -100, 1000, 1000, -50, -60, 3, 7));
        issue(make_pair(bor_pkg::MODE_AREA_A, -100, -100, 1000, 1000, -50, -60, 3, 7));
        // Tiny overlap against the largest area truncates to zero; against the small box it is 1.0.
        issue(make_pair(bor_pkg::MODE_AREA_A, 0, 0, 32767, 32767, 0, 0, 1, 1));
        issue(make_pair(bor_pkg::MODE_AREA_B, 0, 0, 32767, 32767, 0, 0, 1, 1));
        // Hold off until the directed transactions have all come back.
        drain_results();

        // Light sender gaps, then heavy gaps, then back-to-back transactions.
        run_random(PHASE_ITEMS, 36);
        run_random(PHASE_ITEMS, 79);
        run_random(PHASE_ITEMS, 0);

        // Linger past the pipeline depth so a late extra result is still seen.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (ratio_errors == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bor_pkg.sv
hw/rtl/box_overlap_ratio.sv
verif/bor_ratio_check.sv
verif/tb_box_overlap_ratio.sv
